// ===== design/cpbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbf_pkg
// Shared widths and types of the closest pair search block.
// ----------------------------------------------------------------------------
package cpbf_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned DIST_W    = 33;
  localparam int unsigned SQ_W      = 2 * COORD_W;
  localparam int unsigned NUM_BANKS = 2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

endpackage

// ===== design/cpbf_pt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbf_pt_if
// Point request channel: one 2-D point per request, last marks the set end.
// ----------------------------------------------------------------------------
interface cpbf_pt_if import cpbf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic               last_point;

  modport source (output valid, output x_coord, output y_coord, output last_point,
                  input ready);
  modport sink   (input valid, input x_coord, input y_coord, input last_point,
                  output ready);
endinterface

// ===== design/cpbf_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbf_res_if
// Result request channel: closest pair indices and squared distance.
// ----------------------------------------------------------------------------
interface cpbf_res_if import cpbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  first_index;
  logic [IDX_W-1:0]  second_index;
  logic [DIST_W-1:0] squared_distance;
  logic              pair_found;
  logic              overflowed;

  modport source (output valid, output first_index, output second_index,
                  output squared_distance, output pair_found, output overflowed,
                  input ready);
  modport sink   (input valid, input first_index, input second_index,
                  input squared_distance, input pair_found, input overflowed,
                  output ready);
endinterface

// ===== design/closest_pair_brute_force.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_brute_force
// Brute-force closest pair search over a set of signed 2-D points.
//
// Usage: send points on pt_i, one per request, with last_point set on the
// final point of a set. Up to MAX_POINTS points are kept; extra points are
// dropped and reported through overflowed. After the last point the block
// scans every pair in index order and returns one request on res_o with
// the first closest pair, its squared distance and pair_found.
// Points load while a bank is free. The search walks one pair per cycle
// through a four-stage distance pipeline, then drains the pipeline and
// emits the result. Two memory banks let the next set load while the
// previous one is searched; a third set waits until a result has been
// handed to the output register. Reset clears the counters, the job
// queue and the output register; no memory clearing pass is needed.
// While res_o is stalled the result holds, a queued set is searched but
// its result waits, and loading continues while a bank is free.
// ----------------------------------------------------------------------------
module closest_pair_brute_force import cpbf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpbf_pt_if.sink     pt_i,
  cpbf_res_if.source  res_o
);

  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned JW = CW + 2;

  logic          wr_en;
  logic [IW:0]   wr_addr;
  point_t        wr_data;
  logic [IW:0]   rd_addr_a, rd_addr_b;
  point_t        rd_data_a, rd_data_b;
  logic          q_push, q_pop, q_empty, q_full;
  logic [JW-1:0] job_in, job_out;
  logic          bank_release;

  cpbf_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pt_i      (pt_i),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (q_push),
    .job_o     (job_in),
    .release_i (bank_release)
  );

  cpbf_queue #(.W(JW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (job_in),
    .pop_i   (q_pop),
    .data_o  (job_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  cpbf_store #(.MAX_POINTS(MAX_POINTS)) u_store (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  cpbf_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .rd_data_a_i (rd_data_a),
    .rd_data_b_i (rd_data_b),
    .release_o   (bank_release),
    .res_o       (res_o)
  );

`ifndef SYNTHESIS
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job pushed into a full queue");

  a_pop_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job popped from an empty queue");

  a_no_pair_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.pair_found) |->
      (res_o.squared_distance == '0 && res_o.first_index == '0 &&
       res_o.second_index == '0))
    else $error("result without a pair carries nonzero fields");

  a_write_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> pt_i.ready)
    else $error("point written while loading is blocked");
`endif

endmodule

// ===== design/cpbf_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbf_store
// Two-bank point memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module cpbf_store import cpbf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16,
  localparam int unsigned IW = $clog2(MAX_POINTS),
  localparam int unsigned DEPTH = NUM_BANKS * (2 ** IW)
) (
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [IW:0] wr_addr_i,
  input  point_t      wr_data_i,
  input  logic [IW:0] rd_addr_a_i,
  input  logic [IW:0] rd_addr_b_i,
  output point_t      rd_data_a_o,
  output point_t      rd_data_b_o
);

  point_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_a_o <= mem[rd_addr_a_i];
    rd_data_b_o <= mem[rd_addr_b_i];
  end

endmodule

// ===== design/cpbf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbf_queue
// Two-entry job queue between the loading front and the search back end.
// ----------------------------------------------------------------------------
module cpbf_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o,
  output logic         full_o
);

  logic [W-1:0] entry_q [2];
  logic         wr_ptr_q, wr_ptr_d;
  logic         rd_ptr_q, rd_ptr_d;
  logic [1:0]   fill_q, fill_d;
  logic         do_push, do_pop;

  assign empty_o = (fill_q == 2'd0);
  assign full_o  = (fill_q == 2'd2);
  assign data_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/cpbf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbf_front
// Point loader: writes points into the free bank, counts them, flags drops
// and posts a search job on the last point of a set.
// ----------------------------------------------------------------------------
module cpbf_front import cpbf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16,
  localparam int unsigned IW = $clog2(MAX_POINTS),
  localparam int unsigned CW = $clog2(MAX_POINTS + 1),
  localparam int unsigned JW = CW + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cpbf_pt_if.sink       pt_i,
  output logic          wr_en_o,
  output logic [IW:0]   wr_addr_o,
  output point_t        wr_data_o,
  output logic          push_o,
  output logic [JW-1:0] job_o,
  input  logic          release_i
);

  typedef struct packed {
    logic          bank;
    logic [CW-1:0] count;
    logic          dropped;
  } job_t;

  logic          bank_q, bank_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic [1:0]    busy_q, busy_d;
  logic          accept;
  logic          room;
  logic [CW-1:0] count_inc;
  logic          dropped_inc;
  job_t          job;

  assign pt_i.ready  = (busy_q != 2'(NUM_BANKS));
  assign accept      = pt_i.valid && pt_i.ready;
  assign room        = (count_q < CW'(MAX_POINTS));
  assign count_inc   = room ? count_q + CW'(1) : count_q;
  assign dropped_inc = dropped_q || !room;

  assign wr_en_o   = accept && room;
  assign wr_addr_o = {bank_q, count_q[IW-1:0]};
  assign wr_data_o = '{x: pt_i.x_coord, y: pt_i.y_coord};

  assign push_o       = accept && pt_i.last_point;
  assign job.bank     = bank_q;
  assign job.count    = count_inc;
  assign job.dropped  = dropped_inc;
  assign job_o        = job;

  always_comb begin
    bank_d    = bank_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    if (accept) begin
      if (pt_i.last_point) begin
        bank_d    = ~bank_q;
        count_d   = '0;
        dropped_d = 1'b0;
      end else begin
        count_d   = count_inc;
        dropped_d = dropped_inc;
      end
    end
    busy_d = busy_q + 2'(push_o) - 2'(release_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q    <= 1'b0;
      count_q   <= '0;
      dropped_q <= 1'b0;
      busy_q    <= 2'd0;
    end else begin
      bank_q    <= bank_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      busy_q    <= busy_d;
    end
  end

endmodule

// ===== design/cpbf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbf_back
// Pair search: walks every pair of a loaded bank through a four-stage
// distance pipeline, keeps the first strict minimum and emits the result.
// ----------------------------------------------------------------------------
module cpbf_back import cpbf_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16,
  localparam int unsigned IW = $clog2(MAX_POINTS),
  localparam int unsigned CW = $clog2(MAX_POINTS + 1),
  localparam int unsigned JW = CW + 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [JW-1:0] job_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic [IW:0]   rd_addr_a_o,
  output logic [IW:0]   rd_addr_b_o,
  input  point_t        rd_data_a_i,
  input  point_t        rd_data_b_i,
  output logic          release_o,
  cpbf_res_if.source    res_o
);

  typedef struct packed {
    logic          bank;
    logic [CW-1:0] count;
    logic          dropped;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  job_t              job_in;
  logic              bank_q;
  logic [CW-1:0]     count_q;
  logic              dropped_q;
  logic [IW-1:0]     i_q, i_d;
  logic [IW-1:0]     j_q, j_d;
  logic              issue;
  logic              last_j;
  logic              last_pair;

  logic              s1_v_q, s2_v_q, s3_v_q;
  logic [IW-1:0]     s1_i_q, s1_j_q, s2_i_q, s2_j_q, s3_i_q, s3_j_q;
  logic [COORD_W:0]  dx, dy;
  logic [COORD_W-1:0] adx, ady;
  logic [COORD_W-1:0] s2_ax_q, s2_ay_q;
  logic [SQ_W-1:0]   s3_sx_q, s3_sy_q;
  logic [DIST_W-1:0] sum;
  logic              better;

  logic              best_v_q;
  logic [DIST_W-1:0] best_d_q;
  logic [IW-1:0]     best_i_q, best_j_q;

  logic              load_out;
  logic              out_v_q;
  logic [IDX_W-1:0]  out_i_q, out_j_q;
  logic [DIST_W-1:0] out_d_q;
  logic              out_found_q, out_drop_q;

  assign job_in    = job_i;
  assign pop_o     = (state_q == ST_IDLE) && !empty_i;
  assign issue     = (state_q == ST_SCAN);
  assign last_j    = (CW'(j_q) == count_q - CW'(1));
  assign last_pair = last_j && (CW'(i_q) == count_q - CW'(2));
  assign load_out  = (state_q == ST_EMIT) && (!out_v_q || res_o.ready);
  assign release_o = load_out;

  assign rd_addr_a_o = {bank_q, i_q};
  assign rd_addr_b_o = {bank_q, j_q};

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    case (state_q)
      ST_IDLE: begin
        i_d = '0;
        j_d = IW'(1);
        if (!empty_i) begin
          state_d = (job_in.count < CW'(2)) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_pair) begin
          state_d = ST_DRAIN;
        end else if (last_j) begin
          i_d = i_q + IW'(1);
          j_d = IW'(CW'(i_q) + CW'(2));
        end else begin
          j_d = j_q + IW'(1);
        end
      end
      ST_DRAIN: begin
        if (!s1_v_q && !s2_v_q && !s3_v_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      best_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s1_v_q  <= issue;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      if (pop_o) begin
        best_v_q <= 1'b0;
      end else if (better) begin
        best_v_q <= 1'b1;
      end
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;
    j_q <= j_d;
    if (pop_o) begin
      bank_q    <= job_in.bank;
      count_q   <= job_in.count;
      dropped_q <= job_in.dropped;
    end
  end

  // Distance pipeline: read, absolute difference, squares, sum and compare.
  assign dx  = {rd_data_a_i.x[COORD_W-1], rd_data_a_i.x}
             - {rd_data_b_i.x[COORD_W-1], rd_data_b_i.x};
  assign dy  = {rd_data_a_i.y[COORD_W-1], rd_data_a_i.y}
             - {rd_data_b_i.y[COORD_W-1], rd_data_b_i.y};
  assign adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

  assign sum    = DIST_W'(s3_sx_q) + DIST_W'(s3_sy_q);
  assign better = s3_v_q && (!best_v_q || (sum < best_d_q));

  always_ff @(posedge clk_i) begin
    s1_i_q  <= i_q;
    s1_j_q  <= j_q;
    s2_i_q  <= s1_i_q;
    s2_j_q  <= s1_j_q;
    s2_ax_q <= adx;
    s2_ay_q <= ady;
    s3_i_q  <= s2_i_q;
    s3_j_q  <= s2_j_q;
    s3_sx_q <= SQ_W'(s2_ax_q) * SQ_W'(s2_ax_q);
    s3_sy_q <= SQ_W'(s2_ay_q) * SQ_W'(s2_ay_q);
    if (better) begin
      best_d_q <= sum;
      best_i_q <= s3_i_q;
      best_j_q <= s3_j_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_found_q <= best_v_q;
      out_drop_q  <= dropped_q;
      out_i_q     <= best_v_q ? IDX_W'(best_i_q) : '0;
      out_j_q     <= best_v_q ? IDX_W'(best_j_q) : '0;
      out_d_q     <= best_v_q ? best_d_q : '0;
    end
  end

  assign res_o.valid            = out_v_q;
  assign res_o.first_index      = out_i_q;
  assign res_o.second_index     = out_j_q;
  assign res_o.squared_distance = out_d_q;
  assign res_o.pair_found       = out_found_q;
  assign res_o.overflowed       = out_drop_q;

endmodule

// ===== verif/closest_pair_brute_force_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_brute_force_test
// Self-checking bench for the brute-force closest pair search. Point sets are
// streamed in with random idling on both channels. Each accepted point feeds
// a scoreboard that predicts the closest pair, its squared distance and the
// pair_found and overflowed flags. Results are then compared field by field,
// in order. The run covers directed cases (single point, extreme coordinates,
// ties, store overflow) and random sets of many sizes and shapes.
// ----------------------------------------------------------------------------
module closest_pair_brute_force_test import cpbf_pkg::*; ();

  localparam int unsigned MAX_POINTS   = 16;
  localparam int unsigned PHASE_POINTS = 210;
  localparam int unsigned TAIL_CYCLES  = 200;
  localparam longint      TIMEOUT_NS   = 2_000_000;

  typedef enum int {
    COORD_FULL,
    COORD_CLUSTER,
    COORD_EXTREME,
    COORD_MIXED
  } coord_mode_e;

  typedef struct {
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [DIST_W-1:0] squared_distance;
    logic              pair_found;
    logic              overflowed;
  } pair_result_t;

  class pair_scoreboard;
    logic signed [COORD_W-1:0] xs[MAX_POINTS];
    logic signed [COORD_W-1:0] ys[MAX_POINTS];
    int unsigned  loaded;
    bit           dropped;
    pair_result_t expected_q[$];
    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  overflow_sets;
    int unsigned  empty_sets;

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic last);
      pair_result_t     r;
      longint           dx;
      longint           dy;
      longint unsigned  d;
      longint unsigned  best;
      if (loaded < MAX_POINTS) begin
        xs[loaded] = x;
        ys[loaded] = y;
        loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;
      r = '{first_index: '0, second_index: '0, squared_distance: '0,
            pair_found: 1'b0, overflowed: 1'b0};
      best = 0;
      for (int i = 0; i < loaded; i++) begin
        for (int j = i + 1; j < loaded; j++) begin
          dx = longint'(xs[i]) - longint'(xs[j]);
          dy = longint'(ys[i]) - longint'(ys[j]);
          d  = longint'(dx * dx + dy * dy);
          if (!r.pair_found || d < best) begin
            best               = d;
            r.pair_found       = 1'b1;
            r.first_index      = IDX_W'(i);
            r.second_index     = IDX_W'(j);
            r.squared_distance = DIST_W'(d);
          end
        end
      end
      r.overflowed = dropped;
      if (dropped) overflow_sets++;
      if (!r.pair_found) empty_sets++;
      expected_q.push_back(r);
      loaded  = 0;
      dropped = 1'b0;
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want);
      $display("[%0t] mismatch on result %0d, %s: got %0d, expected %0d",
               $realtime, results_checked, what, got, want);
      mismatches++;
    endtask

    task check_result(pair_result_t got);
      pair_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("no result pending", got.squared_distance, 0);
        results_checked++;
        return;
      end
      want = expected_q.pop_front();
      if (got.first_index !== want.first_index)
        report_mismatch("first_index", got.first_index, want.first_index);
      if (got.second_index !== want.second_index)
        report_mismatch("second_index", got.second_index, want.second_index);
      if (got.squared_distance !== want.squared_distance)
        report_mismatch("squared_distance", got.squared_distance, want.squared_distance);
      if (got.pair_found !== want.pair_found)
        report_mismatch("pair_found", got.pair_found, want.pair_found);
      if (got.overflowed !== want.overflowed)
        report_mismatch("overflowed", got.overflowed, want.overflowed);
      results_checked++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  cpbf_pt_if  pt_if ();
  cpbf_res_if res_if ();

  closest_pair_brute_force #(
    .MAX_POINTS(MAX_POINTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pt_i  (pt_if),
    .res_o (res_if)
  );

  pair_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    points_sent;
  int unsigned    sets_sent;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    pair_result_t got;
    if (rst_ni) begin
      if (pt_if.valid && pt_if.ready)
        sb.note_point(pt_if.x_coord, pt_if.y_coord, pt_if.last_point);
      if (res_if.valid && res_if.ready) begin
        got.first_index      = res_if.first_index;
        got.second_index     = res_if.second_index;
        got.squared_distance = res_if.squared_distance;
        got.pair_found       = res_if.pair_found;
        got.overflowed       = res_if.overflowed;
        sb.check_result(got);
      end
    end
  end

  task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                            input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      pt_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pt_if.valid      <= 1'b1;
    pt_if.x_coord    <= x;
    pt_if.y_coord    <= y;
    pt_if.last_point <= last;
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    points_sent++;
    if (last) sets_sent++;
    @(negedge clk_i);
  endtask

  // hold off until every pending result has come back
  task automatic wait_drained();
    pt_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [COORD_W-1:0] pick_coord(coord_mode_e mode,
                                                    logic [COORD_W-1:0] base);
    coord_mode_e m;
    m = mode;
    if (m == COORD_MIXED) m = coord_mode_e'($urandom_range(2));
    case (m)
      COORD_CLUSTER: return base + COORD_W'($urandom_range(6)) - COORD_W'(3);
      COORD_EXTREME: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: return COORD_W'($urandom);
    endcase
  endfunction

  task automatic send_set(input int unsigned n, input coord_mode_e mode);
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    bx = COORD_W'($urandom);
    by = COORD_W'($urandom);
    for (int unsigned k = 0; k < n; k++)
      send_point(pick_coord(mode, bx), pick_coord(mode, by), k == n - 1);
  endtask

  task automatic send_directed();
    int unsigned src;
    send_point(16'h1234, 16'h5678, 1'b1);
    send_point(16'h8000, 16'h8000, 1'b0);
    send_point(16'h7fff, 16'h7fff, 1'b1);
    send_point(16'd0, 16'd0, 1'b0);
    send_point(16'd1, 16'd0, 1'b0);
    send_point(16'd0, 16'd1, 1'b1);
    // duplicate inside the store, and a dropped last point equal to point 0
    for (int unsigned k = 0; k < MAX_POINTS + 2; k++) begin
      src = (k == 12) ? 5 : (k == MAX_POINTS + 1) ? 0 : k;
      send_point(COORD_W'(src * 1000 - 8000), COORD_W'(5000 - src * 700),
                 k == MAX_POINTS + 1);
    end
  endtask

  task automatic send_random_phase();
    int unsigned start;
    int unsigned n;
    int unsigned pick;
    start = points_sent;
    while (points_sent - start < PHASE_POINTS) begin
      pick = $urandom_range(9);
      if (pick < 5)       n = $urandom_range(6, 1);
      else if (pick < 8)  n = $urandom_range(MAX_POINTS, 7);
      else if (pick == 8) n = MAX_POINTS;
      else                n = $urandom_range(MAX_POINTS + 4, MAX_POINTS + 1);
      send_set(n, coord_mode_e'($urandom_range(3)));
      if ($urandom_range(19) == 0) wait_drained();
    end
  endtask

  initial begin
    sb               = new();
    send_idle_pct    = 29;
    recv_idle_pct    = 83;
    points_sent      = 0;
    sets_sent        = 0;
    rst_ni           = 1'b0;
    pt_if.valid      = 1'b0;
    pt_if.x_coord    = '0;
    pt_if.y_coord    = '0;
    pt_if.last_point = 1'b0;
    res_if.ready     = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_directed();
    send_random_phase();
    wait_drained();

    send_idle_pct = 83;
    recv_idle_pct = 29;
    send_random_phase();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_phase();
    wait_drained();

    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Sent %0d points in %0d sets; checked %0d results.",
             points_sent, sets_sent, sb.results_checked);
    $display("Sets with dropped points: %0d, sets without a pair: %0d.",
             sb.overflow_sets, sb.empty_sets);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still pending.", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
